FILE: design/mec_pkg.sv
// ----------------------------------------------------------------------------
// mec_pkg: shared types and constants of the escape count unit
// fixed-point widths, register indexes, lane control word and saturation
// ----------------------------------------------------------------------------
`default_nettype none

package mec_pkg;

  localparam int Q_W             = 32;  // signed q4.28 word
  localparam int FRAC_BITS       = 28;
  localparam int IDX_W           = 10;  // column and row index ports
  localparam int ROW_W           = 11;  // row_base plus lane offset
  localparam int OUT_CNT_W       = 9;
  localparam int NUM_COUNT_PORTS = 8;
  localparam int WIDE_W          = 48;  // headroom for pre-saturation sums
  localparam int SQ_W            = 36;  // floor(x*x / 2^28)
  localparam int CROSS_W         = 37;  // floor(x*y / 2^27)
  localparam int MAG_W           = 37;  // re2 + im2

  // escape bound 4.0 in q4.28
  localparam logic signed [MAG_W-1:0] ESC_LIMIT = 37'sh0_4000_0000;

  typedef enum logic [1:0] {
    REG_X_STEP   = 2'd0,
    REG_X_OFFSET = 2'd1,
    REG_Y_STEP   = 2'd2,
    REG_Y_OFFSET = 2'd3
  } reg_idx_t;

  typedef logic signed [Q_W-1:0] q_t;

  // per-cycle control broadcast from the slot controller to every lane
  typedef struct packed {
    logic ld_en;
    logic ld_slot;
    logic mul_slot;
    logic upd_en;
    logic upd_slot;
  } lane_ctl_t;

  // clamp a wide signed value to the signed 32-bit range
  function automatic q_t sat32(input logic signed [WIDE_W-1:0] v);
    q_t res;
    if ((v[WIDE_W-1:Q_W-1] == '0) || (v[WIDE_W-1:Q_W-1] == '1)) begin
      res = v[Q_W-1:0];
    end else if (v[WIDE_W-1]) begin
      res = 32'sh8000_0000;
    end else begin
      res = 32'sh7FFF_FFFF;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

FILE: design/mandelbrot_escape_count_unit.sv
// ----------------------------------------------------------------------------
// mandelbrot_escape_count_unit: escape-time counter, one column by eight rows
// maps each pixel to c, iterates z = z*z + c and counts steps with |z|^2 < 4
// ----------------------------------------------------------------------------
//
//  channel   ports                                  handshake
//  -------   -------------------------------------  --------------------------
//  input     in_column, in_row_base                 start high while busy low
//  result    out_column, out_row_base, out_count_*  out_valid, one cycle
//  config    psel penable pwrite paddr pwdata ...   apb write, pready tied high
//
//  - each lane runs a loop (multiply, then update) for MAX_ITERATIONS
//    steps; an item's counts are registered in the merge block when its
//    last update is done
//  - the multiply and update stages each serve one of two item slots per
//    cycle, so two words are in flight: a new word can load while the
//    other slot is still iterating
//  - busy follows the slot whose turn it is to load; a start seen while
//    that slot is busy waits for the turn of a free slot
//  - synchronous active-low reset clears the config and control registers
//    to zero and empties both slots; data registers are not reset
//  - results cannot be held off: each word is shown for exactly one cycle
//
`default_nettype none

module mandelbrot_escape_count_unit #(
  parameter int MAX_ITERATIONS = 256,
  parameter int LANES          = 8
) (
  input  wire                        clk,
  input  wire                        rst_n,
  // input word
  input  wire                        start,
  output logic                       busy,
  input  wire  [9:0]                 in_column,
  input  wire  [9:0]                 in_row_base,
  // result word
  output logic                       out_valid,
  output logic [9:0]                 out_column,
  output logic [9:0]                 out_row_base,
  output logic [8:0]                 out_count_0,
  output logic [8:0]                 out_count_1,
  output logic [8:0]                 out_count_2,
  output logic [8:0]                 out_count_3,
  output logic [8:0]                 out_count_4,
  output logic [8:0]                 out_count_5,
  output logic [8:0]                 out_count_6,
  output logic [8:0]                 out_count_7,
  // configuration
  input  wire                        psel,
  input  wire                        penable,
  input  wire                        pwrite,
  input  wire  [3:0]                 paddr,
  input  wire  [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import mec_pkg::*;

  localparam int CNT_W = $clog2(MAX_ITERATIONS + 1);
  localparam int IT_W  = (MAX_ITERATIONS > 1) ? $clog2(MAX_ITERATIONS) : 1;

  // configuration registers
  q_t x_step_r;
  q_t x_offset_r;
  q_t y_step_r;
  q_t y_offset_r;

  // slot control: ph_r picks the slot that multiplies (and may load) now,
  // the other slot is in its update cycle
  logic             ph_r;
  logic             act_r    [2];
  logic [IT_W-1:0]  it_r     [2];
  logic [IDX_W-1:0] col_r    [2];
  logic [IDX_W-1:0] rb_r     [2];
  q_t               cr_r     [2];
  logic             mul_vld_r;

  logic             accept;
  logic             upd_slot;
  logic             fin;
  lane_ctl_t        ctl;

  // real part of c, shared by all lanes
  logic signed [IDX_W+Q_W:0] cr_prod;
  logic signed [WIDE_W-1:0]  cr_wide;
  q_t                        cr_ld;

  logic [LANES-1:0][CNT_W-1:0]               lane_cnt;
  logic [NUM_COUNT_PORTS-1:0][OUT_CNT_W-1:0] count_bus;

  logic cfg_wr;

  // ---------------------------------------------------------------- config
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_step_r   <= '0;
      x_offset_r <= '0;
      y_step_r   <= '0;
      y_offset_r <= '0;
    end else if (cfg_wr) begin
      case (reg_idx_t'(paddr[3:2]))
        REG_X_STEP:   x_step_r   <= pwdata;
        REG_X_OFFSET: x_offset_r <= pwdata;
        REG_Y_STEP:   y_step_r   <= pwdata;
        REG_Y_OFFSET: y_offset_r <= pwdata;
        default:      x_step_r   <= x_step_r;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_t'(paddr[3:2]))
      REG_X_STEP:   prdata = x_step_r;
      REG_X_OFFSET: prdata = x_offset_r;
      REG_Y_STEP:   prdata = y_step_r;
      REG_Y_OFFSET: prdata = y_offset_r;
      default:      prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- load
  // a word loads into the slot whose multiply turn it is, if that slot is free
  assign busy   = act_r[ph_r];
  assign accept = start && !busy;

  always_comb begin
    cr_prod = $signed({1'b0, in_column}) * x_step_r;
    cr_wide = {{(WIDE_W-IDX_W-Q_W-1){cr_prod[IDX_W+Q_W]}}, cr_prod}
            - {{(WIDE_W-Q_W){x_offset_r[Q_W-1]}}, x_offset_r};
    cr_ld   = sat32(cr_wide);
  end

  // ---------------------------------------------------------------- control
  assign upd_slot = ~ph_r;
  assign fin      = mul_vld_r && (it_r[upd_slot] == IT_W'(MAX_ITERATIONS - 1));

  always_comb begin
    ctl.ld_en    = accept;
    ctl.ld_slot  = ph_r;
    ctl.mul_slot = ph_r;
    ctl.upd_en   = mul_vld_r;
    ctl.upd_slot = upd_slot;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r      <= 1'b0;
      mul_vld_r <= 1'b0;
      for (int s = 0; s < 2; s++) begin
        act_r[s] <= 1'b0;
        it_r[s]  <= '0;
      end
    end else begin
      ph_r      <= ~ph_r;
      mul_vld_r <= act_r[ph_r];
      for (int s = 0; s < 2; s++) begin
        if (accept && (ph_r == 1'(s))) begin
          act_r[s] <= 1'b1;
          it_r[s]  <= '0;
        end else if (mul_vld_r && (upd_slot == 1'(s))) begin
          if (fin) begin
            act_r[s] <= 1'b0;
          end else begin
            it_r[s] <= it_r[s] + 1'b1;
          end
        end
      end
    end
  end

  // word tags and shared c real part, held per slot
  always_ff @(posedge clk) begin
    for (int s = 0; s < 2; s++) begin
      if (accept && (ph_r == 1'(s))) begin
        col_r[s] <= in_column;
        rb_r[s]  <= in_row_base;
        cr_r[s]  <= cr_ld;
      end
    end
  end

  // ---------------------------------------------------------------- lanes
  for (genvar k = 0; k < LANES; k++) begin : g_lane
    mec_lane #(
      .LANE_IDX (k),
      .CNT_W    (CNT_W)
    ) u_lane (
      .clk         (clk),
      .ctl         (ctl),
      .ld_row_base (in_row_base),
      .y_step      (y_step_r),
      .y_offset    (y_offset_r),
      .upd_cr      (cr_r[upd_slot]),
      .cnt_fin     (lane_cnt[k])
    );
  end

  // ---------------------------------------------------------------- merge
  mec_merge #(
    .LANES (LANES),
    .CNT_W (CNT_W)
  ) u_merge (
    .clk          (clk),
    .rst_n        (rst_n),
    .fin          (fin),
    .fin_column   (col_r[upd_slot]),
    .fin_row_base (rb_r[upd_slot]),
    .lane_cnt     (lane_cnt),
    .out_valid    (out_valid),
    .out_column   (out_column),
    .out_row_base (out_row_base),
    .out_count    (count_bus)
  );

  assign out_count_0 = count_bus[0];
  assign out_count_1 = count_bus[1];
  assign out_count_2 = count_bus[2];
  assign out_count_3 = count_bus[3];
  assign out_count_4 = count_bus[4];
  assign out_count_5 = count_bus[5];
  assign out_count_6 = count_bus[6];
  assign out_count_7 = count_bus[7];

  // ---------------------------------------------------------------- checks
  // a loaded slot is live and starts from iteration zero
  a_load_slot: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (act_r[~ph_r] && (it_r[~ph_r] == '0)))
    else $error("loaded slot not active at iteration zero");

  // the slot being updated must still hold a live word
  a_upd_live: assert property (@(posedge clk) disable iff (!rst_n)
    mul_vld_r |-> act_r[upd_slot])
    else $error("update issued to an idle slot");

  // a finished slot is free to load on its next turn
  a_fin_free: assert property (@(posedge clk) disable iff (!rst_n)
    fin |=> !busy)
    else $error("finished slot still busy");

endmodule

`default_nettype wire

FILE: design/mec_lane.sv
// ----------------------------------------------------------------------------
// mec_lane: one row of the group
// holds two item slots; multiplies one slot while it updates the other
// ----------------------------------------------------------------------------
`default_nettype none

module mec_lane #(
  parameter int LANE_IDX = 0,
  parameter int CNT_W    = 9
) (
  input  wire                          clk,
  input  wire  mec_pkg::lane_ctl_t     ctl,
  input  wire  [mec_pkg::IDX_W-1:0]    ld_row_base,
  input  wire  signed [mec_pkg::Q_W-1:0] y_step,
  input  wire  signed [mec_pkg::Q_W-1:0] y_offset,
  input  wire  signed [mec_pkg::Q_W-1:0] upd_cr,
  output logic [CNT_W-1:0]             cnt_fin
);
  import mec_pkg::*;

  // per-slot iteration context
  q_t               zr_r  [2];
  q_t               zi_r  [2];
  q_t               ci_r  [2];
  logic [CNT_W-1:0] cnt_r [2];
  logic             esc_r [2];

  // multiply stage outputs
  logic signed [SQ_W-1:0]    re2_r;
  logic signed [SQ_W-1:0]    im2_r;
  logic signed [CROSS_W-1:0] cross_r;

  logic [ROW_W-1:0]          row;
  logic signed [ROW_W+Q_W:0] ci_prod;
  logic signed [WIDE_W-1:0]  ci_wide;
  q_t                        ci_ld;

  q_t                        zr_m;
  q_t                        zi_m;
  logic signed [2*Q_W-1:0]   p_rr;
  logic signed [2*Q_W-1:0]   p_ii;
  logic signed [2*Q_W-1:0]   p_ri;

  logic signed [MAG_W-1:0]   mag;
  logic                      esc_nxt;
  logic [CNT_W-1:0]          cnt_nxt;
  logic signed [WIDE_W-1:0]  zr_sum;
  logic signed [WIDE_W-1:0]  zi_sum;
  q_t                        zr_nxt;
  q_t                        zi_nxt;

  // imaginary part of c for this lane's row
  always_comb begin
    row     = ROW_W'(ld_row_base) + ROW_W'(LANE_IDX);
    ci_prod = $signed({1'b0, row}) * y_step;
    ci_wide = {{(WIDE_W-ROW_W-Q_W-1){ci_prod[ROW_W+Q_W]}}, ci_prod}
            - {{(WIDE_W-Q_W){y_offset[Q_W-1]}}, y_offset};
    ci_ld   = sat32(ci_wide);
  end

  // multiply stage
  always_comb begin
    zr_m = zr_r[ctl.mul_slot];
    zi_m = zi_r[ctl.mul_slot];
    p_rr = zr_m * zr_m;
    p_ii = zi_m * zi_m;
    p_ri = zr_m * zi_m;
  end

  always_ff @(posedge clk) begin
    re2_r   <= p_rr[2*Q_W-1:FRAC_BITS];
    im2_r   <= p_ii[2*Q_W-1:FRAC_BITS];
    cross_r <= p_ri[2*Q_W-1:FRAC_BITS-1];
  end

  // update stage: escape test, count, next z
  always_comb begin
    mag     = {re2_r[SQ_W-1], re2_r} + {im2_r[SQ_W-1], im2_r};
    esc_nxt = esc_r[ctl.upd_slot] || (mag >= ESC_LIMIT);
    cnt_nxt = esc_nxt ? cnt_r[ctl.upd_slot] : cnt_r[ctl.upd_slot] + 1'b1;
    zr_sum  = {{(WIDE_W-SQ_W){re2_r[SQ_W-1]}}, re2_r}
            - {{(WIDE_W-SQ_W){im2_r[SQ_W-1]}}, im2_r}
            + {{(WIDE_W-Q_W){upd_cr[Q_W-1]}}, upd_cr};
    zi_sum  = {{(WIDE_W-CROSS_W){cross_r[CROSS_W-1]}}, cross_r}
            + {{(WIDE_W-Q_W){ci_r[ctl.upd_slot][Q_W-1]}}, ci_r[ctl.upd_slot]};
    zr_nxt  = sat32(zr_sum);
    zi_nxt  = sat32(zi_sum);
  end

  assign cnt_fin = cnt_nxt;

  always_ff @(posedge clk) begin
    for (int s = 0; s < 2; s++) begin
      if (ctl.ld_en && (ctl.ld_slot == 1'(s))) begin
        zr_r[s]  <= '0;
        zi_r[s]  <= '0;
        ci_r[s]  <= ci_ld;
        cnt_r[s] <= '0;
        esc_r[s] <= 1'b0;
      end else if (ctl.upd_en && (ctl.upd_slot == 1'(s))) begin
        cnt_r[s] <= cnt_nxt;
        esc_r[s] <= esc_nxt;
        if (!esc_nxt) begin
          zr_r[s] <= zr_nxt;
          zi_r[s] <= zi_nxt;
        end
      end
    end
  end

endmodule

`default_nettype wire

FILE: design/mec_merge.sv
// ----------------------------------------------------------------------------
// mec_merge: result assembly
// collects the lane counts of a finished slot into the output word
// ----------------------------------------------------------------------------
`default_nettype none

module mec_merge #(
  parameter int LANES = 8,
  parameter int CNT_W = 9
) (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire                                   fin,
  input  wire  [mec_pkg::IDX_W-1:0]             fin_column,
  input  wire  [mec_pkg::IDX_W-1:0]             fin_row_base,
  input  wire  [LANES-1:0][CNT_W-1:0]           lane_cnt,
  output logic                                  out_valid,
  output logic [mec_pkg::IDX_W-1:0]             out_column,
  output logic [mec_pkg::IDX_W-1:0]             out_row_base,
  output logic [mec_pkg::NUM_COUNT_PORTS-1:0][mec_pkg::OUT_CNT_W-1:0] out_count
);
  import mec_pkg::*;

  logic                                      valid_r;
  logic [IDX_W-1:0]                          column_r;
  logic [IDX_W-1:0]                          row_base_r;
  logic [NUM_COUNT_PORTS-1:0][OUT_CNT_W-1:0] count_r;
  logic [NUM_COUNT_PORTS-1:0][OUT_CNT_W-1:0] count_nxt;

  // unused count ports read zero, counts wrap to the port width
  for (genvar k = 0; k < NUM_COUNT_PORTS; k++) begin : g_cnt
    if (k < LANES) begin : g_used
      assign count_nxt[k] = OUT_CNT_W'(lane_cnt[k]);
    end else begin : g_unused
      assign count_nxt[k] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= fin;
    end
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      column_r   <= fin_column;
      row_base_r <= fin_row_base;
      count_r    <= count_nxt;
    end
  end

  assign out_valid    = valid_r;
  assign out_column   = column_r;
  assign out_row_base = row_base_r;
  assign out_count    = count_r;

endmodule

`default_nettype wire

FILE: tb/sv/mec_escape_scoreboard.sv
// ----------------------------------------------------------------------------
// mec_escape_scoreboard: result checker for the escape count unit
// follows register writes, predicts eight lane counts per accepted word and
// compares every result word in order against the oldest prediction
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module mec_escape_scoreboard #(
  parameter int MAX_ITERATIONS = 256,
  parameter int LANES          = 8
) (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        start,
  input  wire        busy,
  input  wire  [9:0] in_column,
  input  wire  [9:0] in_row_base,
  input  wire        out_valid,
  input  wire  [9:0] out_column,
  input  wire  [9:0] out_row_base,
  input  wire  [8:0] out_count_0,
  input  wire  [8:0] out_count_1,
  input  wire  [8:0] out_count_2,
  input  wire  [8:0] out_count_3,
  input  wire  [8:0] out_count_4,
  input  wire  [8:0] out_count_5,
  input  wire  [8:0] out_count_6,
  input  wire  [8:0] out_count_7,
  input  wire        psel,
  input  wire        penable,
  input  wire        pwrite,
  input  wire        pready,
  input  wire  [3:0] paddr,
  input  wire  [31:0] pwdata,
  output int         fail_count,
  output int         pending
);
  import mec_pkg::*;

  typedef struct packed {
    logic [9:0]      column;
    logic [9:0]      row_base;
    logic [7:0][8:0] count;
  } escape_group_t;

  localparam longint ESCAPE_BOUND = longint'(4) <<< FRAC_BITS;
  localparam longint Q_MAX        = 64'sd2147483647;
  localparam longint Q_MIN        = -64'sd2147483648;

  q_t x_step_q   = '0;
  q_t x_offset_q = '0;
  q_t y_step_q   = '0;
  q_t y_offset_q = '0;

  escape_group_t   expected_groups[$];
  escape_group_t   want_group;
  logic [7:0][8:0] got_counts;
  int              errors = 0;

  assign got_counts = {out_count_7, out_count_6, out_count_5, out_count_4,
                       out_count_3, out_count_2, out_count_1, out_count_0};

  function automatic longint clamp_q(input longint v);
    if (v > Q_MAX) return Q_MAX;
    if (v < Q_MIN) return Q_MIN;
    return v;
  endfunction

  // z = z*z + c from zero, counting steps whose old |z|^2 stays below 4
  function automatic logic [8:0] lane_escape_count(input longint cr, input longint ci);
    longint zr;
    longint zi;
    longint re2;
    longint im2;
    longint zr_zi;
    int     n;
    bit     escaped;
    zr = 0;
    zi = 0;
    n = 0;
    escaped = 1'b0;
    for (int it = 0; it < MAX_ITERATIONS; it++) begin
      if (!escaped) begin
        re2   = (zr * zr) >>> FRAC_BITS;
        im2   = (zi * zi) >>> FRAC_BITS;
        zr_zi = (zr * zi) >>> (FRAC_BITS - 1);
        if (re2 + im2 >= ESCAPE_BOUND) begin
          escaped = 1'b1;
        end else begin
          n++;
          zr = clamp_q(re2 - im2 + cr);
          zi = clamp_q(zr_zi + ci);
        end
      end
    end
    return n[8:0];
  endfunction

  function automatic escape_group_t predict_group(input logic [9:0] col,
                                                  input logic [9:0] rb);
    escape_group_t g;
    longint        cr;
    longint        ci;
    g.column   = col;
    g.row_base = rb;
    cr = clamp_q(longint'(col) * longint'(x_step_q) - longint'(x_offset_q));
    for (int k = 0; k < 8; k++) begin
      if (k < LANES) begin
        // rows run past row_base without wrapping
        ci = clamp_q((longint'(rb) + k) * longint'(y_step_q) - longint'(y_offset_q));
        g.count[k] = lane_escape_count(cr, ci);
      end else begin
        g.count[k] = '0;
      end
    end
    return g;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    errors++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      x_step_q   = '0;
      x_offset_q = '0;
      y_step_q   = '0;
      y_offset_q = '0;
      expected_groups.delete();
    end else begin
      // results first: a word taken at this edge cannot be answered at it
      if (out_valid) begin
        if (expected_groups.size() == 0) begin
          report_mismatch($sformatf("result word col %0d row %0d with none expected",
                                    out_column, out_row_base));
        end else begin
          want_group = expected_groups.pop_front();
          if (out_column !== want_group.column)
            report_mismatch($sformatf("out_column got %0d, expected %0d",
                                      out_column, want_group.column));
          if (out_row_base !== want_group.row_base)
            report_mismatch($sformatf("out_row_base got %0d, expected %0d",
                                      out_row_base, want_group.row_base));
          for (int k = 0; k < 8; k++) begin
            if (got_counts[k] !== want_group.count[k])
              report_mismatch($sformatf("col %0d row %0d lane %0d count got %0d, expected %0d",
                                        want_group.column, want_group.row_base, k,
                                        got_counts[k], want_group.count[k]));
          end
        end
      end
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[3:2]))
          REG_X_STEP:   x_step_q   = pwdata;
          REG_X_OFFSET: x_offset_q = pwdata;
          REG_Y_STEP:   y_step_q   = pwdata;
          REG_Y_OFFSET: y_offset_q = pwdata;
          default: ;
        endcase
      end
      if (start && !busy) begin
        expected_groups.push_back(predict_group(in_column, in_row_base));
      end
    end
    fail_count <= errors;
    pending    <= expected_groups.size();
  end

endmodule

FILE: tb/sv/tb_mandelbrot_escape_count_unit.sv
// ----------------------------------------------------------------------------
// tb_mandelbrot_escape_count_unit: stimulus and verdict for the escape counter
// directed corners and random viewports sent in bursts with random gaps,
// register views changed between phases, checking done by the scoreboard
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_mandelbrot_escape_count_unit;
  import mec_pkg::*;

  localparam int     MAX_ITERATIONS  = 256;
  localparam int     LANES           = 8;
  // longest legal quiet stretch is a sender gap plus one full latency
  localparam int     IDLE_LIMIT      = 4000;
  localparam int     RANDOM_PHASES   = 6;
  localparam int     WORDS_PER_PHASE = 125;
  localparam longint Q_ONE           = longint'(1) <<< FRAC_BITS;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        start       = 1'b0;
  logic [9:0]  in_column   = '0;
  logic [9:0]  in_row_base = '0;
  logic        psel        = 1'b0;
  logic        penable     = 1'b0;
  logic        pwrite      = 1'b0;
  logic [3:0]  paddr       = '0;
  logic [31:0] pwdata      = '0;

  wire         busy;
  wire         out_valid;
  wire  [9:0]  out_column;
  wire  [9:0]  out_row_base;
  wire  [8:0]  out_count_0;
  wire  [8:0]  out_count_1;
  wire  [8:0]  out_count_2;
  wire  [8:0]  out_count_3;
  wire  [8:0]  out_count_4;
  wire  [8:0]  out_count_5;
  wire  [8:0]  out_count_6;
  wire  [8:0]  out_count_7;
  wire  [31:0] prdata;
  wire         pready;

  int fail_count;
  int pending;
  int idle_cycles = 0;

  // 12 ns clock
  initial begin
    forever #6 clk = ~clk;
  end

  mandelbrot_escape_count_unit #(
    .MAX_ITERATIONS (MAX_ITERATIONS),
    .LANES          (LANES)
  ) u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_column    (in_column),
    .in_row_base  (in_row_base),
    .out_valid    (out_valid),
    .out_column   (out_column),
    .out_row_base (out_row_base),
    .out_count_0  (out_count_0),
    .out_count_1  (out_count_1),
    .out_count_2  (out_count_2),
    .out_count_3  (out_count_3),
    .out_count_4  (out_count_4),
    .out_count_5  (out_count_5),
    .out_count_6  (out_count_6),
    .out_count_7  (out_count_7),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // scoreboard sits beside the block and only watches its pins
  mec_escape_scoreboard #(
    .MAX_ITERATIONS (MAX_ITERATIONS),
    .LANES          (LANES)
  ) u_scoreboard (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_column    (in_column),
    .in_row_base  (in_row_base),
    .out_valid    (out_valid),
    .out_column   (out_column),
    .out_row_base (out_row_base),
    .out_count_0  (out_count_0),
    .out_count_1  (out_count_1),
    .out_count_2  (out_count_2),
    .out_count_3  (out_count_3),
    .out_count_4  (out_count_4),
    .out_count_5  (out_count_5),
    .out_count_6  (out_count_6),
    .out_count_7  (out_count_7),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .pready       (pready),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  // watchdog: any accepted word, result or register access resets the count
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid || (psel && penable)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("[%0t] watchdog: no progress for %0d cycles", $time, IDLE_LIMIT);
        $display("** mandelbrot_escape_count_unit: FAILED **");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // offer one word and hold it until the edge that takes it
  // busy is sampled before the edge's own updates land
  task automatic send_word(input logic [9:0] col, input logic [9:0] rb);
    start       <= 1'b1;
    in_column   <= col;
    in_row_base <= rb;
    do @(posedge clk); while (busy);
  endtask

  // drop start for a gap, with junk on the data ports the block must ignore
  task automatic rest_sender(input int gap);
    if (gap > 0) begin
      start       <= 1'b0;
      in_column   <= 10'($urandom);
      in_row_base <= 10'($urandom);
      repeat (gap) @(posedge clk);
    end
  endtask

  // block is idle once every predicted result word has come back
  // one extra edge so the scoreboard's count covers the last word taken
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // one apb write, setup then access; psel is left high for the next write
  task automatic write_reg(input reg_idx_t idx, input q_t value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  task automatic write_view(input q_t xs, input q_t xo, input q_t ys, input q_t yo);
    write_reg(REG_X_STEP, xs);
    write_reg(REG_X_OFFSET, xo);
    write_reg(REG_Y_STEP, ys);
    write_reg(REG_Y_OFFSET, yo);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // bursts of back-to-back words, then a gap; gaps land on every slot phase
  task automatic random_phase(input int words);
    int         sent;
    int         burst;
    int         gap_kind;
    logic [9:0] rb;
    sent = 0;
    while (sent < words) begin
      burst = $urandom_range(1, 12);
      for (int i = 0; i < burst && sent < words; i++) begin
        // mostly aligned groups, some arbitrary row bases
        if ($urandom_range(0, 3) != 0) rb = 10'($urandom_range(0, 127) * 8);
        else rb = 10'($urandom);
        send_word(10'($urandom), rb);
        sent++;
      end
      gap_kind = $urandom_range(0, 7);
      if (gap_kind < 2) rest_sender(0);
      else if (gap_kind == 7) rest_sender($urandom_range(200, 320));
      else rest_sender($urandom_range(1, 40));
    end
  endtask

  initial begin
    int     sh;
    longint xs;
    longint ys;
    longint cx;
    longint cy;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // registers at reset: c is zero, every lane runs the full count
    send_word(10'd0, 10'd0);
    send_word(10'd1023, 10'd1016);
    drain_results();

    // classic full view: re in [-2, 1), im in [-1.25, 1.25)
    write_view(32'sd786432, 32'sd536870912, 32'sd655360, 32'sd335544320);
    send_word(10'd0, 10'd0);
    send_word(10'd1023, 10'd0);
    rest_sender(3);
    send_word(10'd0, 10'd1016);
    send_word(10'd1023, 10'd1016);
    send_word(10'd512, 10'd512);
    rest_sender(1);
    // row base off the grid, rows run past the frame
    send_word(10'd1023, 10'd1023);
    send_word(10'd341, 10'd5);
    send_word(10'd700, 10'd504);
    send_word(10'd600, 10'd496);
    drain_results();

    // extreme registers: c saturates on both axes
    write_view(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF);
    send_word(10'd0, 10'd0);
    send_word(10'd1023, 10'd1016);
    drain_results();
    write_view(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000);
    send_word(10'd1023, 10'd1023);
    send_word(10'd1, 10'd8);
    drain_results();

    // c = -2 exactly: |z|^2 lands on the bound, not below it
    write_view(32'sd0, 32'sd536870912, 32'sd0, 32'sd0);
    send_word(10'd5, 10'd8);
    drain_results();

    // c = 0.25, the cusp: slow creep that never escapes
    write_view(32'sd0, -32'sd67108864, 32'sd0, 32'sd0);
    send_word(10'd77, 10'd64);
    drain_results();

    // one lsb steps, tiny c near the origin
    write_view(32'sd1, 32'sd0, -32'sd1, 32'sd0);
    send_word(10'd1023, 10'd1016);
    send_word(10'd0, 10'd1023);
    drain_results();

    // random viewports of varying zoom and sign, last one raw random registers
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p == RANDOM_PHASES - 1) begin
        write_view($urandom, $urandom, $urandom, $urandom);
      end else begin
        sh = $urandom_range(10, 20);
        xs = $urandom_range(1 << (sh - 1), 1 << sh);
        if ($urandom_range(0, 1)) xs = -xs;
        sh = $urandom_range(10, 20);
        ys = $urandom_range(1 << (sh - 1), 1 << sh);
        if ($urandom_range(0, 1)) ys = -ys;
        // centers inside the interesting part of the plane
        cx = longint'($urandom_range(0, 32'(5 * Q_ONE / 2))) - 2 * Q_ONE;
        cy = longint'($urandom_range(0, 32'(5 * Q_ONE / 2))) - 5 * Q_ONE / 4;
        write_view(q_t'(xs), q_t'(512 * xs - cx), q_t'(ys), q_t'(512 * ys - cy));
      end
      random_phase(WORDS_PER_PHASE);
      drain_results();
    end

    // quiet tail to catch stray result words
    repeat (2 * MAX_ITERATIONS + 8) @(posedge clk);

    if (fail_count == 0) begin
      $display("** mandelbrot_escape_count_unit: PASSED **");
    end else begin
      $display("** mandelbrot_escape_count_unit: FAILED **");
    end
    $finish;
  end

endmodule
